// ===== rtl/refcounted_free_list_allocator_assert.svh =====
// Assertion macros for the allocator RTL.
`ifndef REFCOUNTED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCFL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCFL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// ===== rtl/rcfl_pkg.sv =====
`default_nettype none

package rcfl_pkg;

    localparam int MAX_ENTRIES = 512;
    localparam int IDX_W       = 9;
    localparam int SIZE_W      = 10;
    localparam int COUNT_W     = 16;
    localparam int LINK_W      = IDX_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ACT_ALLOC   = 3'd0,
        ACT_FREE    = 3'd1,
        ACT_ADDREF  = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_KILL    = 3'd4,
        ACT_QUERY   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic               cnt_we;
        logic [IDX_W-1:0]   cnt_addr;
        logic [COUNT_W-1:0] cnt_data;
        logic               link_we;
        logic [IDX_W-1:0]   link_addr;
        logic [LINK_W-1:0]  link_data;
        logic               head_we;
        logic               head_valid;
        logic [IDX_W-1:0]   head;
        logic               fill_we;
        logic [SIZE_W-1:0]  fill;
        status_t            status;
        logic [IDX_W-1:0]   entry_out;
        logic [COUNT_W-1:0] count;
    } exec_t;

endpackage

`default_nettype wire

// ===== rtl/rcfl_ram.sv =====
`default_nettype none

module rcfl_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcfl_exec.sv =====
`default_nettype none

module rcfl_exec import rcfl_pkg::*; (
    input  wire logic [2:0]         action,
    input  wire logic [IDX_W-1:0]   entry,
    input  wire logic               head_valid,
    input  wire logic [IDX_W-1:0]   head,
    input  wire logic [SIZE_W-1:0]  fill,
    input  wire logic [SIZE_W-1:0]  pool_size,
    input  wire logic [LINK_W-1:0]  link_rdata,
    input  wire logic [COUNT_W-1:0] cnt_rdata,
    output exec_t                   res
);

    logic               entry_fresh;
    logic               head_fresh;
    logic               in_range;
    logic [COUNT_W-1:0] cur_count;
    logic [LINK_W-1:0]  head_link;
    logic               live;

    // Entries below the fill mark have not been touched since the last relink:
    // their count is zero and they link to the entry just below them.
    always_comb begin
        entry_fresh = {1'b0, entry} < fill;
        head_fresh  = {1'b0, head} < fill;
        in_range    = {1'b0, entry} < pool_size;
        cur_count   = entry_fresh ? '0 : cnt_rdata;
        head_link   = head_fresh ? {(head != '0), head - IDX_W'(1)} : link_rdata;
        live        = in_range && (cur_count != '0);
    end

    always_comb begin
        res            = '0;
        res.status     = ST_BAD;
        res.entry_out  = entry;
        res.head_valid = 1'b1;
        res.head       = entry;
        res.cnt_addr   = entry;
        res.link_addr  = entry;
        res.link_data  = {head_valid, head};
        res.fill       = fill;
        case (action)
            ACT_ALLOC: begin
                if (!head_valid) begin
                    res.status    = ST_EMPTY;
                    res.entry_out = '0;
                end else begin
                    res.status     = ST_OK;
                    res.entry_out  = head;
                    res.count      = COUNT_W'(1);
                    res.cnt_we     = 1'b1;
                    res.cnt_addr   = head;
                    res.cnt_data   = COUNT_W'(1);
                    res.head_we    = 1'b1;
                    res.head_valid = head_link[LINK_W-1];
                    res.head       = head_link[IDX_W-1:0];
                    res.fill_we    = head_fresh;
                    res.fill       = {1'b0, head};
                end
            end
            ACT_FREE, ACT_KILL: begin
                if (live) begin
                    res.status  = ST_OK;
                    res.cnt_we  = 1'b1;
                    res.link_we = 1'b1;
                    res.head_we = 1'b1;
                end
            end
            ACT_ADDREF: begin
                if (live) begin
                    if (cur_count == COUNT_MAX) begin
                        res.status = ST_SAT;
                        res.count  = cur_count;
                    end else begin
                        res.status   = ST_OK;
                        res.count    = cur_count + COUNT_W'(1);
                        res.cnt_we   = 1'b1;
                        res.cnt_data = cur_count + COUNT_W'(1);
                    end
                end
            end
            ACT_RELEASE: begin
                if (live) begin
                    res.status = ST_OK;
                    res.cnt_we = 1'b1;
                    if (cur_count == COUNT_W'(1)) begin
                        res.link_we = 1'b1;
                        res.head_we = 1'b1;
                    end else begin
                        res.count    = cur_count - COUNT_W'(1);
                        res.cnt_data = cur_count - COUNT_W'(1);
                    end
                end
            end
            ACT_QUERY: begin
                if (live) begin
                    res.status = ST_OK;
                    res.count  = cur_count;
                end
            end
            default: begin
                res.status = ST_BAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/refcounted_free_list_allocator.sv =====
// Channel   Direction  Ports                                   Transaction
// s_        in         s_action, s_entry                       one request
// m_        out        m_status, m_entry_out, m_count          one result per request
// cfg_      in         cfg_wdata (pool_size)                   write on cfg_we
//
// On accept a request reads the link and count memories; at its commit the
// memories are written back and the result register is loaded.
// A result still waiting in the output register holds the write-back, and
// s_ready stays low from an accept until its write-back and during reset.
// Reset and pool_size writes relink the pool at once through a fill mark;
// there is no clearing pass. Reset is synchronous and active low.
`default_nettype none

module refcounted_free_list_allocator import rcfl_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [SIZE_W-1:0]  cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_action,
    input  wire logic [IDX_W-1:0]   s_entry,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [IDX_W-1:0]        m_entry_out,
    output logic [COUNT_W-1:0]      m_count
);

    state_t             state_reg, state_next;
    logic [2:0]         action_reg;
    logic [IDX_W-1:0]   entry_reg;
    logic [SIZE_W-1:0]  pool_size_reg;
    logic [SIZE_W-1:0]  fill_reg;
    logic [IDX_W-1:0]   head_reg;
    logic               head_valid_reg;
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic [IDX_W-1:0]   m_entry_out_reg;
    logic [COUNT_W-1:0] m_count_reg;

    logic               accept;
    logic               commit;
    logic [IDX_W-1:0]   rd_addr;
    logic [LINK_W-1:0]  link_rdata;
    logic [COUNT_W-1:0] cnt_rdata;
    logic [SIZE_W-1:0]  cfg_size;
    exec_t              res;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] s;
        s = v;
        if (s == '0) begin
            s = SIZE_W'(1);
        end
        if (s > SIZE_W'(MAX_ENTRIES)) begin
            s = SIZE_W'(MAX_ENTRIES);
        end
        return s;
    endfunction

    assign cfg_size = clamp_size(cfg_wdata);
    assign accept   = s_valid && s_ready;
    assign rd_addr  = (s_action == ACT_ALLOC) ? head_reg : s_entry;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= s_action;
            entry_reg  <= s_entry;
        end
    end

    rcfl_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(LINK_W)) u_link_ram (
        .aclk  (aclk),
        .we    (commit && res.link_we),
        .waddr (res.link_addr),
        .wdata (res.link_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    rcfl_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(COUNT_W)) u_count_ram (
        .aclk  (aclk),
        .we    (commit && res.cnt_we),
        .waddr (res.cnt_addr),
        .wdata (res.cnt_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (cnt_rdata)
    );

    rcfl_exec u_exec (
        .action     (action_reg),
        .entry      (entry_reg),
        .head_valid (head_valid_reg),
        .head       (head_reg),
        .fill       (fill_reg),
        .pool_size  (pool_size_reg),
        .link_rdata (link_rdata),
        .cnt_rdata  (cnt_rdata),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg  <= SIZE_W'(MAX_ENTRIES);
            fill_reg       <= SIZE_W'(MAX_ENTRIES);
            head_reg       <= IDX_W'(MAX_ENTRIES - 1);
            head_valid_reg <= 1'b1;
        end else if (cfg_we) begin
            pool_size_reg  <= cfg_size;
            fill_reg       <= cfg_size;
            head_reg       <= IDX_W'(cfg_size - SIZE_W'(1));
            head_valid_reg <= 1'b1;
        end else if (commit) begin
            if (res.head_we) begin
                head_reg       <= res.head;
                head_valid_reg <= res.head_valid;
            end
            if (res.fill_we) begin
                fill_reg <= res.fill;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_status_reg    <= res.status;
            m_entry_out_reg <= res.entry_out;
            m_count_reg     <= res.count;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_entry_out = m_entry_out_reg;
    assign m_count     = m_count_reg;

`include "refcounted_free_list_allocator_assert.svh"

    `RCFL_ASSERT_NEXT(a_accept_interlock, aclk, aresetn, accept, !s_ready)
    `RCFL_ASSERT_NOW(a_head_in_pool, aclk, aresetn, head_valid_reg, {1'b0, head_reg} < pool_size_reg)
    `RCFL_ASSERT_NOW(a_fill_in_pool, aclk, aresetn, 1'b1, fill_reg <= pool_size_reg)
    `RCFL_ASSERT_NOW(a_empty_result, aclk, aresetn, m_valid && (m_status == ST_EMPTY), (m_count == '0) && (m_entry_out == '0))

endmodule

`default_nettype wire
